/* hdl/dsdr_pkg.sv */
// Shared types, constants and a helper function for the stream/dead aware
// DRRIP replacement block. No dependencies.
package dsdr_pkg;

    localparam int NUM_SETS      = 2048;
    localparam int NUM_WAYS      = 16;
    localparam int LEADER_SETS   = 64;
    localparam int SELECTOR_BITS = 10;

    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int RRPV_W = 2;
    localparam int ADDR_W = 64;
    localparam int STRM_W = 3;
    localparam int DEAD_W = 2;

    localparam logic [RRPV_W-1:0] RRPV_MAX   = 2'd3;
    localparam logic [RRPV_W-1:0] RRPV_NEAR  = 2'd2;
    localparam logic [STRM_W-1:0] STREAM_MAX = 3'd7;
    localparam logic [DEAD_W-1:0] DEAD_MAX   = 2'd3;

    localparam logic [SELECTOR_BITS-1:0] SEL_MID = SELECTOR_BITS'(1 << (SELECTOR_BITS - 1));
    localparam logic [SELECTOR_BITS-1:0] SEL_MAX = {SELECTOR_BITS{1'b1}};

    // Transaction kinds on the input channel.
    localparam logic [1:0] KIND_VICTIM = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    // Reserved kind: accepted and ignored.
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // Configuration register indexes (byte address / 4).
    localparam logic [1:0] REG_DECAY  = 2'd0;
    localparam logic [1:0] REG_STREAM = 2'd1;
    localparam logic [1:0] REG_DEAD   = 2'd2;

    localparam logic [31:0] DECAY_RESET  = 32'd100000;
    localparam logic [STRM_W-1:0] STREAM_THR_RESET = 3'd4;
    localparam logic [DEAD_W-1:0] DEAD_THR_RESET   = 2'd2;

    // One row of per-set state, kept in a single memory word.
    typedef struct packed {
        logic [DEAD_W-1:0]           dead;
        logic [STRM_W-1:0]           stream;
        logic [ADDR_W-1:0]           stride;
        logic [ADDR_W-1:0]           prev_addr;
        logic [NUM_WAYS*RRPV_W-1:0]  rrpv;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    // Lowest set bit of a way mask.
    function automatic logic [WAY_W-1:0] first_set(input logic [NUM_WAYS-1:0] mask);
        logic [WAY_W-1:0] idx;
        idx = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (mask[w]) begin
                idx = WAY_W'(w);
            end
        end
        return idx;
    endfunction

endpackage

/* hdl/drrip_stream_dead_replacement.sv */
// Top level of the stream/dead aware DRRIP replacement block: sequencer,
// per-set state memory and configuration port. Depends on dsdr_pkg,
// dsdr_ram and dsdr_age_unit.
//
// After reset the block clears every row of its per-set memory and holds
// s_tready low meanwhile. It then takes one transaction at a time. A victim
// request with an invalid way answers with the lowest invalid way without a
// row read; otherwise it reads the set row (ST_LOAD) and runs the shared
// aging unit once per aging step in ST_AGE. An update does a row read, a
// stride check, then the RRPV write-back and, on a miss, the dead counter and
// selector update. A heartbeat tick counts toward the decay period, and one
// that ends it starts a sweep (ST_SWRD, then ST_SWWR, for each set) over the
// single-port-read state memory. A new transaction is taken only once the previous result has been taken.
module drrip_stream_dead_replacement
    import dsdr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: set_index[10:0], way_index[14:11], valid_mask[30:15],
    // address[94:31], was_hit[95]
    input  logic [95:0] s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: victim_way[3:0], victim_invalid[4], zero[7:5]
    output logic [7:0]  m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_AGE   = 3'd3;
    localparam logic [2:0] ST_UPD1  = 3'd4;
    localparam logic [2:0] ST_UPD2  = 3'd5;
    localparam logic [2:0] ST_SWRD  = 3'd6;
    localparam logic [2:0] ST_SWWR  = 3'd7;

    logic [2:0]               state_reg, state_next;
    logic [SET_W-1:0]         ptr_reg, ptr_next;
    logic [31:0]              decay_reg;
    logic [STRM_W-1:0]        sthr_reg;
    logic [DEAD_W-1:0]        dthr_reg;
    logic [31:0]              tick_reg, tick_next;
    logic [SELECTOR_BITS-1:0] psel_reg, psel_next;
    logic                     mvalid_reg, mvalid_next;
    logic [WAY_W-1:0]         mway_reg, mway_next;
    logic                     minv_reg, minv_next;

    logic [SET_W-1:0]         set_reg, set_next;
    logic [WAY_W-1:0]         way_reg, way_next;
    logic [ADDR_W-1:0]        addr_reg, addr_next;
    logic                     hit_reg, hit_next;
    logic                     vict_reg, vict_next;
    row_t                     row_reg, row_next;

    logic                     ram_we, ram_re;
    logic [SET_W-1:0]         ram_waddr, ram_raddr;
    row_t                     ram_wdata, ram_rdata;

    logic [NUM_WAYS*RRPV_W-1:0] aged;
    logic                       found;
    logic [WAY_W-1:0]           found_way;

    logic                     accept;
    logic [1:0]               in_kind;
    logic [SET_W-1:0]         in_set;
    logic [NUM_WAYS-1:0]      in_valid;
    logic [ADDR_W-1:0]        stride;
    logic [RRPV_W-1:0]        old_rrpv, depth;
    logic [DEAD_W-1:0]        dead_new;
    logic                     sr_lead, br_lead;
    logic                     cfg_wr;

    dsdr_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dsdr_age_unit u_age (
        .rrpv_in   (row_reg.rrpv),
        .rrpv_aged (aged),
        .found     (found),
        .found_way (found_way)
    );

    assign s_tready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign accept   = s_tvalid && s_tready;
    assign in_kind  = s_tuser;
    assign in_set   = s_tdata[10:0];
    assign in_valid = s_tdata[30:15];

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {3'b000, minv_reg, mway_reg};

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_DECAY:  prdata = decay_reg;
            REG_STREAM: prdata = {29'd0, sthr_reg};
            REG_DEAD:   prdata = {30'd0, dthr_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // Update path helpers: stride, leader classification and fill depth.
    assign stride   = addr_reg - row_reg.prev_addr;
    assign sr_lead  = 32'(set_reg) < 32'(LEADER_SETS / 2);
    assign br_lead  = !sr_lead && (32'(set_reg) < 32'(LEADER_SETS));
    assign old_rrpv = row_reg.rrpv[{way_reg, 1'b0} +: RRPV_W];
    assign dead_new = (old_rrpv == RRPV_MAX && row_reg.dead < DEAD_MAX)
                    ? row_reg.dead + 2'd1 : row_reg.dead;

    always_comb begin
        if (sr_lead) begin
            depth = RRPV_NEAR;
        end else if (br_lead) begin
            depth = RRPV_MAX;
        end else begin
            depth = (psel_reg >= SEL_MID) ? RRPV_NEAR : RRPV_MAX;
        end
        if (row_reg.stream >= sthr_reg || dead_new >= dthr_reg) begin
            depth = RRPV_MAX;
        end
    end

    // Sequencer.
    always_comb begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        tick_next   = tick_reg;
        psel_next   = psel_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mway_next   = mway_reg;
        minv_next   = minv_reg;
        set_next    = set_reg;
        way_next    = way_reg;
        addr_next   = addr_reg;
        hit_next    = hit_reg;
        vict_next   = vict_reg;
        row_next    = row_reg;
        ram_we      = 1'b0;
        ram_waddr   = set_reg;
        ram_wdata   = row_reg;
        ram_re      = 1'b0;
        ram_raddr   = in_set;

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = '0;
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_reg == SET_W'(NUM_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    set_next  = in_set;
                    way_next  = s_tdata[14:11];
                    addr_next = s_tdata[94:31];
                    hit_next  = s_tdata[95];
                    case (in_kind)
                        KIND_VICTIM: begin
                            vict_next = 1'b1;
                            if (~&in_valid) begin
                                mvalid_next = 1'b1;
                                mway_next   = first_set(~in_valid);
                                minv_next   = 1'b1;
                            end else begin
                                ram_re     = 1'b1;
                                state_next = ST_LOAD;
                            end
                        end
                        KIND_UPDATE: begin
                            vict_next  = 1'b0;
                            ram_re     = 1'b1;
                            state_next = ST_LOAD;
                        end
                        KIND_TICK: begin
                            if (tick_reg + 32'd1 >= decay_reg) begin
                                tick_next  = '0;
                                ptr_next   = '0;
                                state_next = ST_SWRD;
                            end else begin
                                tick_next = tick_reg + 32'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                row_next   = ram_rdata;
                state_next = vict_reg ? ST_AGE : ST_UPD1;
            end
            ST_AGE: begin
                if (found) begin
                    ram_we      = 1'b1;
                    mvalid_next = 1'b1;
                    mway_next   = found_way;
                    minv_next   = 1'b0;
                    state_next  = ST_IDLE;
                end else begin
                    row_next.rrpv = aged;
                end
            end
            ST_UPD1: begin
                // Stride detector.
                if (row_reg.stride != '0 && stride == row_reg.stride) begin
                    if (row_reg.stream < STREAM_MAX) begin
                        row_next.stream = row_reg.stream + 3'd1;
                    end
                end else begin
                    row_next.stream = '0;
                end
                row_next.stride    = stride;
                row_next.prev_addr = addr_reg;
                state_next         = ST_UPD2;
            end
            ST_UPD2: begin
                ram_we = 1'b1;
                if (hit_reg) begin
                    ram_wdata.rrpv[{way_reg, 1'b0} +: RRPV_W] = '0;
                end else begin
                    ram_wdata.dead = dead_new;
                    ram_wdata.rrpv[{way_reg, 1'b0} +: RRPV_W] = depth;
                    if (sr_lead) begin
                        if (psel_reg != '0) begin
                            psel_next = psel_reg - 1'b1;
                        end
                    end else if (br_lead) begin
                        if (psel_reg != SEL_MAX) begin
                            psel_next = psel_reg + 1'b1;
                        end
                    end
                end
                state_next = ST_IDLE;
            end
            ST_SWRD: begin
                ram_re     = 1'b1;
                ram_raddr  = ptr_reg;
                state_next = ST_SWWR;
            end
            ST_SWWR: begin
                // Decay both counters of one set.
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                if (ram_rdata.dead != '0) begin
                    ram_wdata.dead = ram_rdata.dead - 2'd1;
                end
                if (ram_rdata.stream != '0) begin
                    ram_wdata.stream = ram_rdata.stream - 3'd1;
                end
                ptr_next   = ptr_reg + 1'b1;
                state_next = (ptr_reg == SET_W'(NUM_SETS - 1)) ? ST_IDLE : ST_SWRD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            ptr_reg    <= '0;
            tick_reg   <= '0;
            psel_reg   <= SEL_MID;
            mvalid_reg <= 1'b0;
            decay_reg  <= DECAY_RESET;
            sthr_reg   <= STREAM_THR_RESET;
            dthr_reg   <= DEAD_THR_RESET;
        end else begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            tick_reg   <= tick_next;
            psel_reg   <= psel_next;
            mvalid_reg <= mvalid_next;
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_DECAY:  decay_reg <= pwdata;
                    REG_STREAM: sthr_reg  <= pwdata[STRM_W-1:0];
                    REG_DEAD:   dthr_reg  <= pwdata[DEAD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        mway_reg <= mway_next;
        minv_reg <= minv_next;
        set_reg  <= set_next;
        way_reg  <= way_next;
        addr_reg <= addr_next;
        hit_reg  <= hit_next;
        vict_reg <= vict_next;
        row_reg  <= row_next;
    end

endmodule

/* hdl/dsdr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/dsdr_age_unit.sv */
// Shared aging unit: one aging step over all RRPVs of a set, plus a search
// for the lowest way at the distant value. Depends on dsdr_pkg.
module dsdr_age_unit
    import dsdr_pkg::*;
(
    input  logic [NUM_WAYS*RRPV_W-1:0] rrpv_in,
    output logic [NUM_WAYS*RRPV_W-1:0] rrpv_aged,
    output logic                       found,
    output logic [WAY_W-1:0]           found_way
);

    logic [NUM_WAYS-1:0] at_max;

    // Per-way saturating increment and distant-value flag.
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            at_max[w] = (rrpv_in[w*RRPV_W +: RRPV_W] == RRPV_MAX);
            rrpv_aged[w*RRPV_W +: RRPV_W] = at_max[w] ? RRPV_MAX
                                          : rrpv_in[w*RRPV_W +: RRPV_W] + 2'd1;
        end
    end

    assign found     = |at_max;
    assign found_way = first_set(at_max);

endmodule
